/* sv/prlm_pkg.sv */
`default_nettype none

package prlm_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W    = 16;
    localparam int LEVEL_W     = 7;
    localparam int FLOOR_W     = 8;
    localparam int THRESH_W    = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOOR_DB        = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_THRESHOLD = 1'd1;

    // Configuration reset values (floor of -60 dB, alarm disabled).
    localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = 8'hC4;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd0;

    // Full scale square is 2^30; log2 mantissa keeps 31 bits.
    localparam int FULL_SCALE_LOG2 = 30;
    localparam int MANT_W          = 31;

    // 10*log10(2) in Q16.
    localparam int K_FRAC = 16;
    localparam int K_W    = 18;
    localparam logic [K_W-1:0] DB_PER_LOG2_Q16 = 18'd197283;

    // Level quotient: 0..100 fits seven bits, one bit per divider step.
    localparam int QUO_W     = 7;
    localparam int QUO_CNT_W = 3;

    // Log unit phases.
    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQUARE,
        LOG_DONE
    } log_phase_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOG_SUM,
        S_LOG_TALLY,
        S_ATT,
        S_NUM,
        S_DIV_LOAD,
        S_DIV,
        S_PEAK,
        S_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic log_start_sum;
        logic log_start_tally;
        logic latch_ls;
        logic latch_a;
        logic calc_att;
        logic calc_num;
        logic load_div;
        logic div_step;
        logic set_zero;
        logic peak_update;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_case;
        logic log_done;
        logic att_ge_full;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* sv/prlm_log2.sv */
`default_nettype none

module prlm_log2 #(
    parameter int IN_W   = 47,
    parameter int FRAC_W = 8,
    localparam int EXP_W = $clog2(IN_W),
    localparam int RES_W = EXP_W + FRAC_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IN_W-1:0]  x,
    output logic             done,
    output logic [RES_W-1:0] result
);
    import prlm_pkg::*;

    localparam int ITER_W = $clog2(FRAC_W);

    log_phase_t          phase_reg, phase_next;
    logic [IN_W-1:0]     word_reg;
    logic [EXP_W-1:0]    shift_reg;
    logic [MANT_W-1:0]   y_reg;
    logic [RES_W-1:0]    r_reg;
    logic [ITER_W-1:0]   iter_reg;

    logic                load;
    logic                top8_zero;
    logic                msb_set;
    logic                last_iter;
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     sq;
    logic [MANT_W-1:0]   y_sq;

    assign top8_zero = (word_reg[IN_W-1 -: 8] == 8'd0);
    assign msb_set   = word_reg[IN_W-1];
    assign last_iter = (iter_reg == ITER_W'(FRAC_W - 1));

    // One squaring per cycle refines one fraction bit.
    assign prod = (2*MANT_W)'(y_reg) * (2*MANT_W)'(y_reg);
    assign sq   = prod[2*MANT_W-1 -: MANT_W+1];
    assign y_sq = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            LOG_IDLE:   if (start) phase_next = LOG_NORM;
            LOG_NORM:   if (msb_set) phase_next = LOG_SQUARE;
            LOG_SQUARE: if (last_iter) phase_next = LOG_DONE;
            LOG_DONE:   phase_next = start ? LOG_NORM : LOG_IDLE;
            default:    phase_next = LOG_IDLE;
        endcase
    end

    // Phase outputs.
    always_comb
    begin
        done = 1'b0;
        load = 1'b0;
        case (phase_reg)
            LOG_IDLE: load = start;
            LOG_DONE:
            begin
                done = 1'b1;
                load = start;
            end
            default:
            begin
                done = 1'b0;
                load = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LOG_IDLE;
            shift_reg <= '0;
            iter_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (load)
            begin
                shift_reg <= '0;
            end
            else if (phase_reg == LOG_NORM)
            begin
                if (top8_zero)
                    shift_reg <= shift_reg + EXP_W'(8);
                else if (!msb_set)
                    shift_reg <= shift_reg + EXP_W'(1);
                iter_reg <= '0;
            end
            else if (phase_reg == LOG_SQUARE)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
        end
    end

    // Normalization moves the leading one to the top; squaring builds the fraction.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= x;
        end
        else if (phase_reg == LOG_NORM)
        begin
            if (top8_zero)
                word_reg <= word_reg << 8;
            else if (!msb_set)
                word_reg <= word_reg << 1;
            else
            begin
                y_reg <= word_reg[IN_W-1 -: MANT_W];
                r_reg <= RES_W'(EXP_W'(IN_W - 1) - shift_reg);
            end
        end
        else if (phase_reg == LOG_SQUARE)
        begin
            y_reg <= y_sq;
            r_reg <= {r_reg[RES_W-2:0], sq[MANT_W]};
        end
    end

    assign result = r_reg;

endmodule

`default_nettype wire

/* sv/prlm_ctrl.sv */
`default_nettype none

module prlm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 frame_last,
    input  logic                 packet_last,
    input  prlm_pkg::dp_status_t status,
    output logic                 in_stall,
    output prlm_pkg::dp_cmd_t    cmd
);
    import prlm_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        pkt_reg, pkt_next;
    logic        accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    // Remember whether the accepted transaction closes a packet.
    assign pkt_next = accept ? packet_last : pkt_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && frame_last)
                    state_next = S_CHECK;
                else if (accept && packet_last)
                    state_next = S_EMIT;
            end
            S_CHECK:     state_next = status.zero_case ? S_PEAK : S_LOG_SUM;
            S_LOG_SUM:   if (status.log_done) state_next = S_LOG_TALLY;
            S_LOG_TALLY: if (status.log_done) state_next = S_ATT;
            S_ATT:       state_next = S_NUM;
            S_NUM:       state_next = status.att_ge_full ? S_PEAK : S_DIV_LOAD;
            S_DIV_LOAD:  state_next = S_DIV;
            S_DIV:       if (status.div_last) state_next = S_PEAK;
            S_PEAK:      state_next = pkt_reg ? S_EMIT : S_IDLE;
            S_EMIT:      if (status.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE: cmd.accept = accept;
            S_CHECK:
            begin
                cmd.set_zero      = status.zero_case;
                cmd.log_start_sum = !status.zero_case;
            end
            S_LOG_SUM:
            begin
                cmd.latch_ls        = status.log_done;
                cmd.log_start_tally = status.log_done;
            end
            S_LOG_TALLY: cmd.latch_a = status.log_done;
            S_ATT:       cmd.calc_att = 1'b1;
            S_NUM:
            begin
                cmd.set_zero = status.att_ge_full;
                cmd.calc_num = !status.att_ge_full;
            end
            S_DIV_LOAD:  cmd.load_div = 1'b1;
            S_DIV:       cmd.div_step = 1'b1;
            S_PEAK:      cmd.peak_update = 1'b1;
            S_EMIT:      cmd.emit = status.out_free;
            default:     cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pkt_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pkt_reg   <= pkt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/prlm_dp.sv */
`default_nettype none

module prlm_dp #(
    parameter int MAX_FRAME_SAMPLES = 65536,
    parameter int LOG_FRAC_BITS     = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  prlm_pkg::dp_cmd_t                     cmd,
    output prlm_pkg::dp_status_t                  status,
    input  logic                                  cfg_we,
    input  logic [prlm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [prlm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [prlm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  sample_valid,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic [prlm_pkg::LEVEL_W-1:0]          level,
    output logic                                  alarm,
    output logic                                  fresh
);
    import prlm_pkg::*;

    localparam int TALLY_W = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int SUM_W   = FULL_SCALE_LOG2 + TALLY_W;
    localparam int EXP_W   = $clog2(SUM_W);
    localparam int LOG_W   = EXP_W + LOG_FRAC_BITS;
    localparam int D_W     = LOG_W + 2;
    localparam int A_W     = LOG_W + 1;
    localparam int ATT_W   = A_W + K_W;
    localparam int FULL_W  = FLOOR_W + LOG_FRAC_BITS + K_FRAC;
    localparam int CMP_W   = (ATT_W > FULL_W) ? ATT_W : FULL_W;
    localparam int DIV_W   = FULL_W + 8;
    localparam int SQ_W    = 2 * SAMPLE_W;
    localparam logic [D_W-1:0] LOG_OFFSET = D_W'(FULL_SCALE_LOG2) << LOG_FRAC_BITS;

    // Configuration.
    logic [FLOOR_W-1:0]  floor_reg;
    logic [THRESH_W-1:0] thresh_reg;

    // Frame and packet state.
    logic [SUM_W-1:0]   sum_reg;
    logic [TALLY_W-1:0] tally_reg;
    logic [LEVEL_W-1:0] peak_reg;
    logic               peak_valid_reg;
    logic [LEVEL_W-1:0] held_reg;

    // Frame level working registers.
    logic [LOG_W-1:0]     ls_reg;
    logic [A_W-1:0]       a_reg;
    logic [ATT_W-1:0]     att_reg;
    logic [FULL_W-1:0]    num_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_CNT_W-1:0] div_cnt_reg;

    // Result register.
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic               alarm_reg;
    logic               fresh_reg;

    logic signed [SQ_W-1:0] square;
    logic                   tally_open;
    logic [SUM_W-1:0]       log_x;
    logic                   log_start;
    logic                   log_done;
    logic [LOG_W-1:0]       log_res;
    logic signed [D_W-1:0]  diff;
    logic [D_W-1:0]         diff_neg;
    logic [A_W-1:0]         a_next;
    logic [FLOOR_W-1:0]     floor_mag;
    logic [FULL_W-1:0]      full;
    logic [CMP_W-1:0]       num_wide;
    logic [DIV_W-1:0]       num_ext;
    logic [DIV_W-1:0]       div_sub;
    logic                   rem_ge;
    logic [LEVEL_W-1:0]     emit_level;
    logic                   out_free;

    // Shared log2 unit, used first for the sum and then for the count.
    assign log_start = cmd.log_start_sum || cmd.log_start_tally;
    assign log_x     = cmd.log_start_tally ? SUM_W'(tally_reg) : sum_reg;

    prlm_log2 #(
        .IN_W   (SUM_W),
        .FRAC_W (LOG_FRAC_BITS)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    assign square     = sample * sample;
    assign tally_open = (tally_reg < TALLY_W'(MAX_FRAME_SAMPLES));

    // Attenuation below full scale in log2 units, clamped at zero.
    assign diff     = $signed(D_W'(ls_reg) - D_W'(log_res) - LOG_OFFSET);
    assign diff_neg = D_W'(0) - D_W'(diff);
    assign a_next   = diff[D_W-1] ? diff_neg[A_W-1:0] : '0;

    // Span from the floor up to full scale, scaled to the attenuation's units.
    assign floor_mag = FLOOR_W'(0) - floor_reg;
    assign full      = FULL_W'(floor_mag) << (LOG_FRAC_BITS + K_FRAC);
    assign num_wide  = CMP_W'(full) - CMP_W'(att_reg);
    assign num_ext   = DIV_W'(num_reg);

    // Restoring division by twice the span, one quotient bit per cycle.
    assign div_sub = (DIV_W'(full) << 1) << div_cnt_reg;
    assign rem_ge  = (rem_reg >= div_sub);

    assign emit_level = peak_valid_reg ? peak_reg : held_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    // Status back to the controller.
    assign status.zero_case   = (tally_reg == '0) || (sum_reg == '0) || !floor_reg[FLOOR_W-1];
    assign status.log_done    = log_done;
    assign status.att_ge_full = (CMP_W'(att_reg) >= CMP_W'(full));
    assign status.div_last    = (div_cnt_reg == '0);
    assign status.out_free    = out_free;

    // Configuration writes, accumulation and packet state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg      <= FLOOR_RESET;
            thresh_reg     <= THRESH_RESET;
            sum_reg        <= '0;
            tally_reg      <= '0;
            peak_reg       <= '0;
            peak_valid_reg <= 1'b0;
            held_reg       <= '0;
            out_valid_reg  <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FLOOR_DB:        floor_reg  <= cfg_data[FLOOR_W-1:0];
                    CFG_ALARM_THRESHOLD: thresh_reg <= cfg_data[THRESH_W-1:0];
                    default:             floor_reg  <= floor_reg;
                endcase
            end

            if (cmd.accept && sample_valid && tally_open)
            begin
                sum_reg   <= sum_reg + SUM_W'(square[FULL_SCALE_LOG2:0]);
                tally_reg <= tally_reg + TALLY_W'(1);
            end
            else if (cmd.peak_update)
            begin
                sum_reg   <= '0;
                tally_reg <= '0;
            end

            if (cmd.peak_update)
            begin
                if (!peak_valid_reg || (quo_reg > peak_reg))
                    peak_reg <= quo_reg;
                peak_valid_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                if (peak_valid_reg)
                    held_reg <= peak_reg;
                peak_valid_reg <= 1'b0;
            end

            if (cmd.load_div)
                div_cnt_reg <= QUO_CNT_W'(QUO_W - 1);
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg - QUO_CNT_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Frame level arithmetic and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_ls)
            ls_reg <= log_res;
        if (cmd.latch_a)
            a_reg <= a_next;
        if (cmd.calc_att)
            att_reg <= ATT_W'(a_reg) * ATT_W'(DB_PER_LOG2_Q16);
        if (cmd.calc_num)
            num_reg <= num_wide[FULL_W-1:0];

        // 200 * num + span: numerator of the rounded quotient.
        if (cmd.load_div)
        begin
            rem_reg <= (num_ext << 7) + (num_ext << 6) + (num_ext << 3) + DIV_W'(full);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg              <= rem_reg - div_sub;
                quo_reg[div_cnt_reg] <= 1'b1;
            end
        end
        else if (cmd.set_zero)
        begin
            quo_reg <= '0;
        end

        if (cmd.emit)
        begin
            level_reg <= emit_level;
            fresh_reg <= peak_valid_reg;
            alarm_reg <= (thresh_reg != '0) && (emit_level >= thresh_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign alarm     = alarm_reg;
    assign fresh     = fresh_reg;

endmodule

`default_nettype wire

/* sv/pcm_rms_level_meter_top.sv */
// A packet end without a frame end goes to the emit state; its result is registered once the
// output register is free. A frame end stalls input for a zero check, two log2 passes (shifts
// of 8 or 1, then one squaring per fraction bit), attenuation, numerator, division and a peak
// update; a zero case skips to the peak update. Throughput: one transaction per cycle between
// ends; a packet end stalls until its result is registered; it waits there as input resumes.
// Reset: asynchronous, active-low rst_n clears sums, counts and levels; registers go to defaults.
`default_nettype none

module pcm_rms_level_meter_top #(
    parameter int MAX_FRAME_SAMPLES = 65536,
    parameter int LOG_FRAC_BITS     = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [prlm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  sample_valid,
    input  logic                                  frame_last,
    input  logic                                  packet_last,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [prlm_pkg::LEVEL_W-1:0]          level,
    output logic                                  alarm,
    output logic                                  fresh,
    input  logic                                  cfg_we,
    input  logic [prlm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [prlm_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import prlm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    prlm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .frame_last  (frame_last),
        .packet_last (packet_last),
        .status      (status),
        .in_stall    (in_stall),
        .cmd         (cmd)
    );

    prlm_dp #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES),
        .LOG_FRAC_BITS     (LOG_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .sample_valid (sample_valid),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .level        (level),
        .alarm        (alarm),
        .fresh        (fresh)
    );

`ifndef ASSERT_OFF
    // A delivered level never exceeds the top of the scale.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> level <= 7'd100)
        else $error("level above 100");

    // An alarm needs a nonzero level, since a zero threshold disables it.
    a_alarm_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm |-> level != 7'd0)
        else $error("alarm with zero level");

    // A frame end starts the level computation, so input stalls next cycle.
    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && frame_last |=> in_stall)
        else $error("no stall after frame end");

    // A plain sample transaction never stalls the following one.
    a_plain_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !frame_last && !packet_last |=> !in_stall)
        else $error("stall after plain sample");
`endif

endmodule

`default_nettype wire

/* tb/meter_level_check.sv */
module meter_level_check (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [prlm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  sample_valid,
    input  logic                                  frame_last,
    input  logic                                  packet_last,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [prlm_pkg::LEVEL_W-1:0]          level,
    input  logic                                  alarm,
    input  logic                                  fresh,
    input  logic                                  cfg_we,
    input  logic [prlm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [prlm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output int                                    fail_count,
    output int                                    pending,
    output int                                    results_seen,
    output int                                    fresh_seen,
    output int                                    alarm_seen
);
    import prlm_pkg::*;

    localparam int MAX_FRAME_SAMPLES = 65536;
    localparam int LOG_FRAC_BITS     = 8;
    // 10*log10(2) in Q16, the dB value of one log2 step.
    localparam longint unsigned DB_STEP_Q16 = 197283;
    // Full scale square is 2^30.
    localparam longint FULL_SCALE_EXP = 30;
    localparam int MAX_PRINTED = 30;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               alarm;
        logic               fresh;
    } meter_result_t;

    // Packet results predicted but not yet seen on the output.
    meter_result_t pending_levels [$];

    // Predicted block state and registers.
    logic [46:0]                square_sum;
    logic [16:0]                sample_tally;
    int                         packet_peak;
    logic [LEVEL_W-1:0]         held_level;
    logic signed [FLOOR_W-1:0]  floor_db;
    logic [THRESH_W-1:0]        alarm_threshold;

    // Truncated log2 with LOG_FRAC_BITS fraction bits, by repeated squaring
    // of a mantissa normalized to 2^30.
    function automatic longint log2_q(input longint unsigned x);
        int              e;
        longint unsigned y;
        longint          r;
        e = 63;
        while (e > 0 && x[e] == 1'b0)
            e--;
        if (e > 30)
            y = x >> (e - 30);
        else
            y = x << (30 - e);
        r = e;
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            y = (y * y) >> 30;
            r = r * 2;
            if (y >= (64'd1 << 31))
            begin
                y = y >> 1;
                r = r + 1;
            end
        end
        return r;
    endfunction

    // Level 0..100 of one closed frame from its square sum and sample count.
    function automatic int frame_score(input longint unsigned sum,
                                       input longint unsigned tally,
                                       input logic signed [FLOOR_W-1:0] floor_v);
        longint          d;
        longint unsigned att;
        longint unsigned full;
        longint unsigned f;
        if (tally == 0 || sum == 0 || floor_v >= 0)
            return 0;
        f = -longint'(floor_v);
        d = log2_q(sum) - log2_q(tally) - (FULL_SCALE_EXP << LOG_FRAC_BITS);
        // A mean square above full scale counts as no attenuation.
        att = (d > 0) ? 64'd0 : longint'(-d) * DB_STEP_Q16;
        full = f << (LOG_FRAC_BITS + 16);
        if (att >= full)
            return 0;
        return int'((200 * (full - att) + full) / (2 * full));
    endfunction

    task automatic report_mismatch(input string what, input int seen, input int wanted);
        if (fail_count < MAX_PRINTED)
            $display("[%0t] level meter mismatch: %s: got %0d, expected %0d",
                     $time, what, seen, wanted);
        fail_count++;
    endtask

    // Follow register writes and transactions on both channels.
    always @(posedge clk or negedge rst_n)
    begin : track
        meter_result_t   want;
        longint unsigned sq;
        int              score;
        if (!rst_n)
        begin
            square_sum      = '0;
            sample_tally    = '0;
            packet_peak     = -1;
            held_level      = '0;
            floor_db        = FLOOR_RESET;
            alarm_threshold = THRESH_RESET;
            pending_levels.delete();
            fail_count      = 0;
            results_seen    = 0;
            fresh_seen      = 0;
            alarm_seen      = 0;
            pending        <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FLOOR_DB)
                    floor_db = cfg_data;
                else if (cfg_index == CFG_ALARM_THRESHOLD)
                    alarm_threshold = cfg_data[THRESH_W-1:0];
            end

            // Accepted input: accumulate, close the frame, close the packet.
            if (in_valid && !in_stall)
            begin
                if (sample_valid && sample_tally < MAX_FRAME_SAMPLES)
                begin
                    sq = longint'(sample) * longint'(sample);
                    square_sum = square_sum + sq[46:0];
                    sample_tally = sample_tally + 1'b1;
                end
                if (frame_last)
                begin
                    score = frame_score(square_sum, sample_tally, floor_db);
                    if (score > packet_peak)
                        packet_peak = score;
                    square_sum = '0;
                    sample_tally = '0;
                end
                if (packet_last)
                begin
                    if (packet_peak < 0)
                    begin
                        want.level = held_level;
                        want.fresh = 1'b0;
                    end
                    else
                    begin
                        want.level = LEVEL_W'(packet_peak);
                        held_level = want.level;
                        want.fresh = 1'b1;
                    end
                    packet_peak = -1;
                    want.alarm = (alarm_threshold != 0) && (want.level >= alarm_threshold);
                    pending_levels.push_back(want);
                end
            end

            // Accepted result: compare with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_levels.size() == 0)
                    report_mismatch("result with no packet pending, level", level, -1);
                else
                begin
                    want = pending_levels.pop_front();
                    if (level !== want.level)
                        report_mismatch("level", level, want.level);
                    if (alarm !== want.alarm)
                        report_mismatch("alarm", alarm, want.alarm);
                    if (fresh !== want.fresh)
                        report_mismatch("fresh", fresh, want.fresh);
                    if (want.fresh)
                        fresh_seen++;
                    if (want.alarm)
                        alarm_seen++;
                end
            end

            pending <= pending_levels.size();
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    import prlm_pkg::*;

    localparam int RANDOM_ITEMS   = 900;
    localparam int NUM_PHASES     = 9;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample       = '0;
    logic                        sample_valid = 1'b0;
    logic                        frame_last   = 1'b0;
    logic                        packet_last  = 1'b0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [LEVEL_W-1:0]          level;
    logic                        alarm;
    logic                        fresh;
    logic                        cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;

    int fail_count;
    int pending;
    int results_seen;
    int fresh_seen;
    int alarm_seen;
    int items_sent     = 0;
    int settings_count = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit idle_on        = 1'b1;
    bit stall_on       = 1'b1;

    always #1 clk = ~clk;

    pcm_rms_level_meter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .sample_valid (sample_valid),
        .frame_last   (frame_last),
        .packet_last  (packet_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level        (level),
        .alarm        (alarm),
        .fresh        (fresh),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    meter_level_check u_level_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .sample_valid (sample_valid),
        .frame_last   (frame_last),
        .packet_last  (packet_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .level        (level),
        .alarm        (alarm),
        .fresh        (fresh),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .fresh_seen   (fresh_seen),
        .alarm_seen   (alarm_seen)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random sample whose magnitude stays below 2^bits; 16 means any value.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input int bits);
        int mag;
        if (bits >= 16)
            return SAMPLE_W'($urandom());
        mag = $urandom_range(0, (1 << bits) - 1);
        return SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
    endfunction

    // Receiver stalls the result channel in random bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 2) == 0)
        begin
            stall_left <= pick_gap();
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // One input transaction, after an optional idle gap.
    task automatic send_item(input logic [SAMPLE_W-1:0] value, input logic valid_bit,
                             input logic end_frame, input logic end_packet);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample       <= value;
        sample_valid <= valid_bit;
        frame_last   <= end_frame;
        packet_last  <= end_packet;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Hold off input until every predicted result has come out, then let
    // any frame-end computation that produces no result finish.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the floor register and then the threshold register; the block is idle here.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] floor_v,
                                  input logic [THRESH_W-1:0] thr_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FLOOR_DB;
        cfg_data  <= floor_v;
        @(posedge clk);
        cfg_index <= CFG_ALARM_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr_v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_count++;
    endtask

    // A well-formed packet: zero to three frames of random loudness, with
    // markers sprinkled in, ending in one of several ways.
    task automatic send_packet();
        int frames;
        int ending;
        int n;
        int bits;
        int r;
        logic close_here;
        frames = $urandom_range(0, 3);
        ending = $urandom_range(0, 9);
        for (int f = 0; f < frames; f++)
        begin
            close_here = (f == frames - 1) && (ending >= 2);
            r = $urandom_range(0, 9);
            n = (r == 0) ? 0 : (r < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            bits = $urandom_range(0, 16);
            if (n == 0)
                send_item(pick_sample(16), 1'b0, 1'b1, close_here);
            else
                for (int i = 0; i < n; i++)
                    send_item(pick_sample(bits), $urandom_range(0, 7) != 0,
                              i == n - 1, (i == n - 1) && close_here);
        end
        if (frames == 0 || ending < 2)
        begin
            // Open samples that carry over into the next packet, or a bare marker.
            if (ending == 0)
            begin
                n = $urandom_range(1, 3);
                bits = $urandom_range(0, 16);
                for (int i = 0; i < n; i++)
                    send_item(pick_sample(bits), 1'b1, 1'b0, i == n - 1);
            end
            else
                send_item(pick_sample(16), 1'b0, 1'b0, 1'b1);
        end
    endtask

    // A short burst of transactions with random flags.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_item(SAMPLE_W'($urandom()), $urandom_range(0, 1) == 1,
                      $urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0);
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] floor_v;
        logic [THRESH_W-1:0]   thr_v;
        int                    target;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases under the reset settings.
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);     // packet without frames
        send_item(16'h8000, 1'b0, 1'b1, 1'b1);     // empty frame, sample not counted
        send_item(16'h8000, 1'b1, 1'b1, 1'b1);     // full scale
        send_item(16'h7FFF, 1'b1, 1'b1, 1'b0);
        send_item(16'h0000, 1'b1, 1'b1, 1'b1);     // silent frame after a loud one
        send_item(16'h0000, 1'b0, 1'b0, 1'b1);     // held level re-emitted
        send_item(16'd1000, 1'b1, 1'b0, 1'b1);     // packet end leaves the frame open
        send_item(-16'sd1000, 1'b1, 1'b1, 1'b1);
        send_item(16'h7FFF, 1'b0, 1'b0, 1'b0);     // marker only
        send_item(16'd1, 1'b1, 1'b1, 1'b1);        // below the floor
        send_item(16'd300, 1'b1, 1'b1, 1'b0);      // quiet frame, then a louder one
        send_item(16'd20000, 1'b1, 1'b1, 1'b1);
        send_item(16'h5555, 1'b1, 1'b0, 1'b0);
        send_item(16'hAAAA, 1'b0, 1'b0, 1'b0);
        send_item(16'h2AAA, 1'b1, 1'b1, 1'b1);
        drain_results();

        // Random packets, each phase under its own register settings.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin floor_v = -8'sd120; thr_v = 7'd1;   end
                1:       begin floor_v = -8'sd1;   thr_v = 7'd100; end
                2:       begin floor_v = 8'h80;    thr_v = 7'd127; end
                3:       begin floor_v = 8'd0;     thr_v = 7'd50;  end
                4:       begin floor_v = 8'd127;   thr_v = 7'd20;  end
                5:       begin floor_v = -8'sd60;  thr_v = 7'd0;   end
                6:       begin floor_v = -8'sd90;  thr_v = 7'd60;  end
                7:
                begin
                    floor_v = CFG_DATA_W'(-int'($urandom_range(1, 120)));
                    thr_v   = THRESH_W'($urandom_range(0, 100));
                end
                default:
                begin
                    floor_v = CFG_DATA_W'($urandom_range(0, 255));
                    thr_v   = THRESH_W'($urandom_range(0, 127));
                end
            endcase
            apply_settings(floor_v, thr_v);
            target = items_sent + RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < target)
            begin
                idle_on = $urandom_range(0, 4) != 0;
                stall_on <= $urandom_range(0, 4) != 0;
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_packet();
                if ($urandom_range(0, 24) == 0)
                    drain_results();
            end
            drain_results();
        end

        $display("Sent %0d input transactions under %0d register settings, with idle gaps,",
                 items_sent, settings_count);
        $display("result stalls, open frames and markers; checked %0d packet results:",
                 results_seen);
        $display("%0d with new frames, %0d with the alarm raised.", fresh_seen, alarm_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* pcm_rms_level_meter_top.f */
sv/prlm_pkg.sv
sv/prlm_log2.sv
sv/prlm_ctrl.sv
sv/prlm_dp.sv
sv/pcm_rms_level_meter_top.sv
tb/meter_level_check.sv
tb/testbench.sv
